// File: src/bfd_pkg.sv
// Shared types and constants for the box-filter downscaler.
// No dependencies; imported by the control, divider and top-level modules.
package bfd_pkg;

  localparam int unsigned NUM_CH         = 4;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned PIX_MAX        = 255;

  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 15;

  localparam int unsigned SRC_DIM_W      = 15;
  localparam int unsigned SRC_DIM_MAX    = 16384;
  localparam int unsigned SRC_POS_W      = 14;
  localparam int unsigned OUT_DIM_W      = 11;
  localparam int unsigned OUT_HEIGHT_MAX = 1024;
  localparam int unsigned OUT_ROW_W      = 11;
  localparam int unsigned SCALE_REG_W    = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_OUT_WIDTH  = 3'd2,
    CFG_OUT_HEIGHT = 3'd3,
    CFG_SCALE      = 3'd4
  } cfg_idx_e;

  // Position markers carried along with a block result.
  typedef struct packed {
    logic row_end;
    logic image_end;
  } bfd_tag_t;

  // What the raster counters say about one accepted pixel.
  typedef struct packed {
    logic     active;
    logic     first;
    logic     last;
    bfd_tag_t tag;
  } bfd_item_t;

endpackage

// File: src/bfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bfd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bfd_ctrl.sv
// Configuration registers and raster counters of the downscaler.
// Depends on bfd_pkg; classifies each accepted pixel and steps the counters.
module bfd_ctrl import bfd_pkg::*; #(
  parameter int unsigned MAX_OUT_WIDTH = 1024,
  parameter int unsigned MAX_SCALE     = 16,
  localparam int unsigned ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
  localparam int unsigned SCV_W  = $clog2(MAX_SCALE + 1),
  localparam int unsigned DIV_W  = 2 * SCV_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  step_i,
  output bfd_item_t             item_o,
  output logic [ADDR_W-1:0]     addr_o,
  output logic [DIV_W-1:0]      divisor_o
);

  localparam int unsigned OW_W  = $clog2(MAX_OUT_WIDTH + 1);
  localparam int unsigned SUB_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic [SRC_DIM_W-1:0]   src_width_q, src_height_q;
  logic [OUT_DIM_W-1:0]   out_width_q, out_height_q;
  logic [SCALE_REG_W-1:0] scale_q;

  logic [SRC_POS_W-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [SUB_W-1:0]     sub_col_q, sub_col_d, sub_row_q, sub_row_d;
  logic [OW_W-1:0]      out_col_q, out_col_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;

  logic [SRC_DIM_W-1:0] sw, sh;
  logic [OW_W-1:0]      ow;
  logic [OUT_ROW_W-1:0] oh;
  logic [SCV_W-1:0]     sc;
  logic                 col_last, row_last;

  // Effective register values: zero acts as one, large values clip.
  always_comb begin
    if (src_width_q == '0) begin
      sw = SRC_DIM_W'(1);
    end else if (32'(src_width_q) > SRC_DIM_MAX) begin
      sw = SRC_DIM_W'(SRC_DIM_MAX);
    end else begin
      sw = src_width_q;
    end
    if (src_height_q == '0) begin
      sh = SRC_DIM_W'(1);
    end else if (32'(src_height_q) > SRC_DIM_MAX) begin
      sh = SRC_DIM_W'(SRC_DIM_MAX);
    end else begin
      sh = src_height_q;
    end
    if (out_width_q == '0) begin
      ow = OW_W'(1);
    end else if (32'(out_width_q) > MAX_OUT_WIDTH) begin
      ow = OW_W'(MAX_OUT_WIDTH);
    end else begin
      ow = OW_W'(out_width_q);
    end
    if (out_height_q == '0) begin
      oh = OUT_ROW_W'(1);
    end else if (32'(out_height_q) > OUT_HEIGHT_MAX) begin
      oh = OUT_ROW_W'(OUT_HEIGHT_MAX);
    end else begin
      oh = OUT_ROW_W'(out_height_q);
    end
    if (scale_q == '0) begin
      sc = SCV_W'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      sc = SCV_W'(MAX_SCALE);
    end else begin
      sc = SCV_W'(scale_q);
    end
  end

  assign divisor_o = DIV_W'(sc) * DIV_W'(sc);
  assign addr_o    = out_col_q[ADDR_W-1:0];

  always_comb begin
    item_o.active        = (out_row_q < oh) && (out_col_q < ow);
    item_o.first         = (sub_row_q == '0) && (sub_col_q == '0);
    item_o.last          = (SCV_W'(sub_row_q) == sc - SCV_W'(1)) &&
                           (SCV_W'(sub_col_q) == sc - SCV_W'(1));
    item_o.tag.row_end   = (out_col_q == ow - OW_W'(1));
    item_o.tag.image_end = item_o.tag.row_end && (out_row_q == oh - OUT_ROW_W'(1));
  end

  assign col_last = ({1'b0, src_col_q} >= sw - SRC_DIM_W'(1));
  assign row_last = ({1'b0, src_row_q} >= sh - SRC_DIM_W'(1));

  // Advance the raster position; wrap at row and image end.
  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    sub_col_d = sub_col_q;
    sub_row_d = sub_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (col_last) begin
      src_col_d = '0;
      sub_col_d = '0;
      out_col_d = '0;
      if (row_last) begin
        src_row_d = '0;
        sub_row_d = '0;
        out_row_d = '0;
      end else begin
        src_row_d = src_row_q + SRC_POS_W'(1);
        if (out_row_q < oh) begin
          if (SCV_W'(sub_row_q) >= sc - SCV_W'(1)) begin
            sub_row_d = '0;
            out_row_d = out_row_q + OUT_ROW_W'(1);
          end else begin
            sub_row_d = sub_row_q + SUB_W'(1);
          end
        end
      end
    end else begin
      src_col_d = src_col_q + SRC_POS_W'(1);
      if (out_col_q < ow) begin
        if (SCV_W'(sub_col_q) >= sc - SCV_W'(1)) begin
          sub_col_d = '0;
          out_col_d = out_col_q + OW_W'(1);
        end else begin
          sub_col_d = sub_col_q + SUB_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_DIM_W'(1);
      src_height_q <= SRC_DIM_W'(1);
      out_width_q  <= OUT_DIM_W'(1);
      out_height_q <= OUT_DIM_W'(1);
      scale_q      <= SCALE_REG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SRC_DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[SRC_DIM_W-1:0];
        CFG_OUT_WIDTH:  out_width_q  <= cfg_data_i[OUT_DIM_W-1:0];
        CFG_OUT_HEIGHT: out_height_q <= cfg_data_i[OUT_DIM_W-1:0];
        CFG_SCALE:      scale_q      <= cfg_data_i[SCALE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      sub_col_q <= '0;
      sub_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (step_i) begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      sub_col_q <= sub_col_d;
      sub_row_q <= sub_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// File: src/bfd_div.sv
// Four-lane restoring divider: block sums over scale squared, one bit per cycle.
// Depends on bfd_pkg; saturates each quotient to the pixel range.
module bfd_div import bfd_pkg::*; #(
  parameter int unsigned SUM_W = 16,
  parameter int unsigned DIV_W = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [NUM_CH-1:0][SUM_W-1:0]      sum_i,
  input  logic [DIV_W-1:0]                  divisor_i,
  input  bfd_tag_t                          tag_i,
  output logic                              ready_o,
  output logic                              res_valid_o,
  input  logic                              res_take_i,
  output logic [NUM_CH-1:0][PIX_W-1:0]      avg_o,
  output bfd_tag_t                          tag_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_e;

  div_state_e                     state_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [DIV_W-1:0]               divisor_q;
  logic [NUM_CH-1:0][DIV_W-1:0]   rem_q, rem_d;
  logic [NUM_CH-1:0][SUM_W-1:0]   quo_q, quo_d;
  bfd_tag_t                       tag_q;
  logic [DIV_W:0]                 trial [NUM_CH];

  // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      trial[c] = {rem_q[c], quo_q[c][SUM_W-1]};
      quo_d[c] = {quo_q[c][SUM_W-2:0], 1'b0};
      if (trial[c] >= {1'b0, divisor_q}) begin
        rem_d[c]    = DIV_W'(trial[c] - {1'b0, divisor_q});
        quo_d[c][0] = 1'b1;
      end else begin
        rem_d[c] = trial[c][DIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      unique case (state_q)
        DIV_IDLE: begin
          if (start_i) begin
            state_q   <= DIV_RUN;
            cnt_q     <= CNT_W'(SUM_W - 1);
            divisor_q <= divisor_i;
            rem_q     <= '0;
            quo_q     <= sum_i;
            tag_q     <= tag_i;
          end
        end
        DIV_RUN: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= DIV_HOLD;
          end
        end
        DIV_HOLD: begin
          if (res_take_i) begin
            state_q <= DIV_IDLE;
          end
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  assign ready_o     = (state_q == DIV_IDLE);
  assign res_valid_o = (state_q == DIV_HOLD);
  assign tag_o       = tag_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (quo_q[c] > SUM_W'(PIX_MAX)) begin
        avg_o[c] = PIX_W'(PIX_MAX);
      end else begin
        avg_o[c] = quo_q[c][PIX_W-1:0];
      end
    end
  end

endmodule

// File: src/box_filter_downscale_rgba8_top.sv
// Box-filter downscaler, 8-bit RGBA. Throughput: one pixel per cycle, except that a
// pixel closing a block waits while the divider is busy with the previous block: while
// it works out the SUM_W quotient bits bit-serially (SUM_W is 16 at MAX_SCALE 16) and
// while its result is held back by a stalled output. A block's result passes from the
// update stage through the divider to the output register.
// Reset: registers to 1, counters to zero; the column-sum RAM is not cleared, since
// the first pixel of each block overwrites its entry.
module box_filter_downscale_rgba8_top import bfd_pkg::*; #(
  parameter int unsigned MAX_OUT_WIDTH = 1024,
  parameter int unsigned MAX_SCALE     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      src_red_i,
  input  logic [PIX_W-1:0]      src_green_i,
  input  logic [PIX_W-1:0]      src_blue_i,
  input  logic [PIX_W-1:0]      src_alpha_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      avg_red_o,
  output logic [PIX_W-1:0]      avg_green_o,
  output logic [PIX_W-1:0]      avg_blue_o,
  output logic [PIX_W-1:0]      avg_alpha_o,
  output logic                  row_end_o,
  output logic                  image_end_o
);

  localparam int unsigned ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int unsigned SCV_W  = $clog2(MAX_SCALE + 1);
  localparam int unsigned DIV_W  = 2 * SCV_W;
  localparam int unsigned SUM_W  = $clog2(MAX_SCALE * MAX_SCALE * PIX_MAX + 1);
  localparam int unsigned MEM_W  = NUM_CH * SUM_W;

  logic                              accept;
  bfd_item_t                         item;
  logic [ADDR_W-1:0]                 rd_addr;
  logic [DIV_W-1:0]                  divisor;

  logic                              b_valid_q;
  bfd_item_t                         b_item_q;
  logic [ADDR_W-1:0]                 b_addr_q;
  logic [NUM_CH-1:0][PIX_W-1:0]      b_px_q;
  logic                              b_done;

  logic [MEM_W-1:0]                  rdata;
  logic [NUM_CH-1:0][SUM_W-1:0]      base, acc;
  logic                              wr_en;

  logic                              fwd_valid_q;
  logic [ADDR_W-1:0]                 fwd_addr_q;
  logic [NUM_CH-1:0][SUM_W-1:0]      fwd_data_q;

  logic                              div_ready, div_start, div_valid, div_take;
  logic [NUM_CH-1:0][PIX_W-1:0]      div_avg;
  bfd_tag_t                          div_tag;

  logic                              out_valid_q;
  logic [NUM_CH-1:0][PIX_W-1:0]      out_avg_q;
  bfd_tag_t                          out_tag_q;

  bfd_ctrl #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_SCALE     (MAX_SCALE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (accept),
    .item_o     (item),
    .addr_o     (rd_addr),
    .divisor_o  (divisor)
  );

  // A block-closing pixel holds the update stage until the divider is free.
  assign b_done     = b_valid_q && !(b_item_q.active && b_item_q.last && !div_ready);
  assign in_stall_o = b_valid_q && !b_done;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (accept) begin
      b_valid_q <= 1'b1;
    end else if (b_done) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_item_q  <= item;
      b_addr_q  <= rd_addr;
      b_px_q[0] <= src_red_i;
      b_px_q[1] <= src_green_i;
      b_px_q[2] <= src_blue_i;
      b_px_q[3] <= src_alpha_i;
    end
  end

  bfd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (b_addr_q),
    .wdata_i (acc),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // The read may have been issued on the same edge as the last write; forward it.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == b_addr_q)) begin
      base = fwd_data_q;
    end else begin
      base = rdata;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (b_item_q.first) begin
        acc[c] = SUM_W'(b_px_q[c]);
      end else begin
        acc[c] = base[c] + SUM_W'(b_px_q[c]);
      end
    end
  end

  assign wr_en     = b_done && b_item_q.active;
  assign div_start = wr_en && b_item_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= b_addr_q;
      fwd_data_q <= acc;
    end
  end

  bfd_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .sum_i       (acc),
    .divisor_i   (divisor),
    .tag_i       (b_item_q.tag),
    .ready_o     (div_ready),
    .res_valid_o (div_valid),
    .res_take_i  (div_take),
    .avg_o       (div_avg),
    .tag_o       (div_tag)
  );

  // Output register: load a finished quotient when empty or being drained.
  assign div_take = div_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_take) begin
      out_avg_q <= div_avg;
      out_tag_q <= div_tag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign avg_red_o   = out_avg_q[0];
  assign avg_green_o = out_avg_q[1];
  assign avg_blue_o  = out_avg_q[2];
  assign avg_alpha_o = out_avg_q[3];
  assign row_end_o   = out_tag_q.row_end;
  assign image_end_o = out_tag_q.image_end;

endmodule

// File: bench/tb_box_filter_downscale_rgba8_top.sv
// Self-checking bench for box_filter_downscale_rgba8_top: streams RGBA frames through
// the valid/stall channels and compares every block average with its own prediction.
// Depends on bfd_pkg and the top-level RTL only.
module tb_box_filter_downscale_rgba8_top import bfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_OUT_W     = 1024;
  localparam int unsigned MAX_SC        = 16;
  localparam int unsigned DRAIN_PAUSE   = 40;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned RANDOM_PIXELS = 450;
  localparam int unsigned PRINT_CAP     = 200;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             row_end;
    logic             image_end;
  } block_avg_t;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      src_red_i   = '0;
  logic [PIX_W-1:0]      src_green_i = '0;
  logic [PIX_W-1:0]      src_blue_i  = '0;
  logic [PIX_W-1:0]      src_alpha_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      avg_red_o;
  logic [PIX_W-1:0]      avg_green_o;
  logic [PIX_W-1:0]      avg_blue_o;
  logic [PIX_W-1:0]      avg_alpha_o;
  logic                  row_end_o;
  logic                  image_end_o;

  box_filter_downscale_rgba8_top #(
    .MAX_OUT_WIDTH (MAX_OUT_W),
    .MAX_SCALE     (MAX_SC)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .src_red_i   (src_red_i),
    .src_green_i (src_green_i),
    .src_blue_i  (src_blue_i),
    .src_alpha_i (src_alpha_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .avg_red_o   (avg_red_o),
    .avg_green_o (avg_green_o),
    .avg_blue_o  (avg_blue_o),
    .avg_alpha_o (avg_alpha_o),
    .row_end_o   (row_end_o),
    .image_end_o (image_end_o)
  );

  // Shadow of the geometry registers and the raster walk.
  logic [SRC_DIM_W-1:0]   reg_src_w = 1;
  logic [SRC_DIM_W-1:0]   reg_src_h = 1;
  logic [OUT_DIM_W-1:0]   reg_out_w = 1;
  logic [OUT_DIM_W-1:0]   reg_out_h = 1;
  logic [SCALE_REG_W-1:0] reg_scale = 1;
  int unsigned col_sum [MAX_OUT_W][NUM_CH];
  int unsigned src_col = 0, src_row = 0, sub_col = 0, sub_row = 0;
  int unsigned out_col = 0, out_row = 0;

  block_avg_t  pending_avgs[$];
  int unsigned err_count      = 0;
  int unsigned counted_pixels = 0;
  int unsigned cycle_count    = 0;
  int unsigned rx_hold_left   = 0;
  bit          steady         = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [PIX_W-1:0] floor_avg(input int unsigned sum,
                                                 input int unsigned div);
    int unsigned q;
    q = sum / div;
    return (q > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(q);
  endfunction

  function automatic int unsigned frame_pixels();
    return eff(reg_src_w, SRC_DIM_MAX) * eff(reg_src_h, SRC_DIM_MAX);
  endfunction

  // Accumulate one source pixel and advance the raster; returns 1 when a block closes.
  function automatic bit step_downscale(input pixel_t px, output block_avg_t avg,
                                        output bit in_block);
    int unsigned sw, sh, ow, oh, sc, div;
    int unsigned ch [NUM_CH];
    bit first, closes;
    sw = eff(reg_src_w, SRC_DIM_MAX);
    sh = eff(reg_src_h, SRC_DIM_MAX);
    ow = eff(reg_out_w, MAX_OUT_W);
    oh = eff(reg_out_h, OUT_HEIGHT_MAX);
    sc = eff(reg_scale, MAX_SC);
    ch[0] = px.red;
    ch[1] = px.green;
    ch[2] = px.blue;
    ch[3] = px.alpha;
    avg = '0;
    closes = 1'b0;
    in_block = 1'b0;
    if (out_row < oh && out_col < ow) begin
      in_block = 1'b1;
      first = (sub_row == 0 && sub_col == 0);
      for (int c = 0; c < NUM_CH; c++)
        col_sum[out_col][c] = first ? ch[c] : col_sum[out_col][c] + ch[c];
      if (sub_row == sc - 1 && sub_col == sc - 1) begin
        div = sc * sc;
        avg.red       = floor_avg(col_sum[out_col][0], div);
        avg.green     = floor_avg(col_sum[out_col][1], div);
        avg.blue      = floor_avg(col_sum[out_col][2], div);
        avg.alpha     = floor_avg(col_sum[out_col][3], div);
        avg.row_end   = (out_col == ow - 1);
        avg.image_end = (out_col == ow - 1) && (out_row == oh - 1);
        closes = 1'b1;
      end
    end
    if (src_col >= sw - 1) begin
      src_col = 0;
      sub_col = 0;
      out_col = 0;
      if (src_row >= sh - 1) begin
        src_row = 0;
        sub_row = 0;
        out_row = 0;
      end else begin
        src_row++;
        if (out_row < oh) begin
          if (sub_row >= sc - 1) begin
            sub_row = 0;
            out_row++;
          end else begin
            sub_row++;
          end
        end
      end
    end else begin
      src_col++;
      if (out_col < ow) begin
        if (sub_col >= sc - 1) begin
          sub_col = 0;
          out_col++;
        end else begin
          sub_col++;
        end
      end
    end
    return closes;
  endfunction

  task automatic flag_error(input string msg);
    if (err_count < PRINT_CAP)
      $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Called at a falling edge while the block is idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_SRC_WIDTH:  reg_src_w = val;
      CFG_SRC_HEIGHT: reg_src_h = val;
      CFG_OUT_WIDTH:  reg_out_w = val[OUT_DIM_W-1:0];
      CFG_OUT_HEIGHT: reg_out_h = val[OUT_DIM_W-1:0];
      CFG_SCALE:      reg_scale = val[SCALE_REG_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_geometry(input int unsigned sw, input int unsigned sh,
                               input int unsigned ow, input int unsigned oh,
                               input int unsigned sc);
    write_reg(CFG_SRC_WIDTH,  CFG_DATA_W'(sw));
    write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(sh));
    write_reg(CFG_OUT_WIDTH,  CFG_DATA_W'(ow));
    write_reg(CFG_OUT_HEIGHT, CFG_DATA_W'(oh));
    write_reg(CFG_SCALE,      CFG_DATA_W'(sc));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold the input quiet until every block average is back, then let the pipe settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_avgs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_PAUSE) @(negedge clk_i);
  endtask

  task automatic send_pixel(input pixel_t px);
    block_avg_t avg;
    bit         in_block;
    while (!steady && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    src_red_i   <= px.red;
    src_green_i <= px.green;
    src_blue_i  <= px.blue;
    src_alpha_i <= px.alpha;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (step_downscale(px, avg, in_block))
      pending_avgs.push_back(avg);
    if (in_block)
      counted_pixels++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int unsigned count);
    repeat (count) send_pixel(pixel_t'($urandom));
  endtask

  // Zeroed registers act as 1x1 at scale 1, so each pixel comes back unchanged.
  task automatic test_channel_extremes();
    pixel_t corners [8];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h55AA_55AA, 32'hAA55_AA55,
                32'h0102_0408, 32'h1020_4080, 32'h7F7F_7F7F, 32'h8080_8080};
    load_geometry(0, 0, 0, 0, 0);
    foreach (corners[i]) send_pixel(corners[i]);
    wait_drained();
    // full-scale sums at scale 2, one just short of the top
    load_geometry(2, 2, 1, 1, 2);
    repeat (3) send_pixel(32'hFFFF_FFFF);
    send_pixel({8'hFF, 8'hFE, 8'h00, 8'h01});
    wait_drained();
  endtask

  task automatic test_block_edges();
    // source narrower and shorter than the output grid: cut blocks drop out
    load_geometry(3, 3, 2, 2, 2);
    send_frame(frame_pixels());
    wait_drained();
    // surplus source columns and rows are skipped
    load_geometry(3, 3, 1, 1, 2);
    send_frame(frame_pixels());
    wait_drained();
  endtask

  task automatic test_extreme_sizes();
    steady = 1'b1;
    // over-range output size clamps, zero scale acts as 1
    load_geometry(4, 2, 2047, 2047, 0);
    send_frame(frame_pixels());
    wait_drained();
    // tall narrow source, surplus rows and columns past the output grid skipped
    load_geometry(2, 24, 1, 20, 1);
    send_frame(frame_pixels());
    wait_drained();
    // over-range scale clamps to the largest block
    load_geometry(MAX_SC + 1, MAX_SC, 1, 1, 31);
    send_frame(frame_pixels());
    wait_drained();
    steady = 1'b0;
  endtask

  // Receiver holds off, first while every pixel closes a block, then at scale 2 over two frames, so the block backs up.
  task automatic test_backpressure();
    load_geometry(8, 8, 8, 8, 1);
    rx_hold_left = 300;
    send_frame(frame_pixels());
    wait_drained();
    load_geometry(8, 4, 4, 2, 2);
    rx_hold_left = 150;
    send_frame(2 * frame_pixels());
    wait_drained();
  endtask

  task automatic test_random_images();
    int unsigned sc, ow, oh, sw, sh, frames;
    counted_pixels = 0;
    while (counted_pixels < RANDOM_PIXELS) begin
      sc = ($urandom_range(7) == 0) ? $urandom_range(5, MAX_SC) : $urandom_range(1, 4);
      ow = (sc > 4) ? 1 : $urandom_range(1, 6);
      oh = (sc > 4) ? 1 : $urandom_range(1, 4);
      sw = ow * sc + $urandom_range(0, 3);
      sh = oh * sc + $urandom_range(0, 2);
      // now and then cut the last block column or row short
      if (sc > 1 && $urandom_range(7) == 0)
        sw = ow * sc - $urandom_range(1, sc - 1);
      if (sc > 1 && $urandom_range(7) == 0)
        sh = oh * sc - $urandom_range(1, sc - 1);
      frames = (sc > 4) ? 1 : $urandom_range(1, 3);
      load_geometry(sw, sh, ow, oh, sc);
      repeat (frames) send_frame(frame_pixels());
      wait_drained();
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 36);
    end
  end

  always @(posedge clk_i) begin : check_avgs
    block_avg_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_avgs.size() == 0) begin
        flag_error("block average with none pending");
      end else begin
        want = pending_avgs.pop_front();
        if (avg_red_o !== want.red)
          flag_error($sformatf("avg_red %0d, want %0d", avg_red_o, want.red));
        if (avg_green_o !== want.green)
          flag_error($sformatf("avg_green %0d, want %0d", avg_green_o, want.green));
        if (avg_blue_o !== want.blue)
          flag_error($sformatf("avg_blue %0d, want %0d", avg_blue_o, want.blue));
        if (avg_alpha_o !== want.alpha)
          flag_error($sformatf("avg_alpha %0d, want %0d", avg_alpha_o, want.alpha));
        if (row_end_o !== want.row_end)
          flag_error($sformatf("row_end %b, want %b", row_end_o, want.row_end));
        if (image_end_o !== want.image_end)
          flag_error($sformatf("image_end %b, want %b", image_end_o, want.image_end));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[box_filter_downscale_rgba8_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_channel_extremes();
    test_block_edges();
    test_extreme_sizes();
    test_backpressure();
    test_random_images();
    wait_drained();
    if (err_count == 0 && pending_avgs.size() == 0) begin
      $display("[box_filter_downscale_rgba8_top] OK");
    end else begin
      $display("[box_filter_downscale_rgba8_top] ERROR");
    end
    $finish;
  end

endmodule
